>>> hdl/pending_order_trigger_matcher_top_assert.svh
// Assertion macros for the pending order trigger matcher.
`ifndef PENDING_ORDER_TRIGGER_MATCHER_TOP_ASSERT_SVH
`define PENDING_ORDER_TRIGGER_MATCHER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define POPTM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define POPTM_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
`else
`define POPTM_ASSERT(lbl, clk, rstn, prop, msg)
`define POPTM_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg)
`endif

`endif

>>> hdl/poptm_pkg.sv
// ----------------------------------------------------------------------------
// poptm_pkg
// Types and codes shared by the pending order trigger matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package poptm_pkg;

  localparam int unsigned RES_CAP = 64;
  localparam int unsigned RCW     = 7;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_TICK    = 3'd2;
  localparam logic [2:0] OP_CLR_PF  = 3'd3;
  localparam logic [2:0] OP_CLR_ALL = 3'd4;

  localparam logic [1:0] RK_ACK    = 2'd0;
  localparam logic [1:0] RK_FILL   = 2'd1;
  localparam logic [1:0] RK_NOFILL = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_PF    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [1:0] KIND_LIMIT   = 2'd0;
  localparam logic [1:0] KIND_STOP    = 2'd1;
  localparam logic [1:0] KIND_STOPLIM = 2'd2;

  localparam logic SIDE_BUY = 1'b0;

  typedef enum logic [2:0] {
    CMD_ADD,
    CMD_REMOVE,
    CMD_TICK,
    CMD_CLR_PF,
    CMD_CLR_ALL,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [15:0] ord_id;
    logic [7:0]  portfolio;
    logic [11:0] symbol;
    logic [1:0]  okind;
    logic        side;
    logic [31:0] limit;
    logic [31:0] stop;
    logic [31:0] qty;
    logic [31:0] bid;
    logic [31:0] ask;
    logic [31:0] last;
  } cmd_t;

  typedef struct packed {
    logic [15:0] ord_id;
    logic [7:0]  portfolio;
    logic [11:0] symbol;
    logic [1:0]  okind;
    logic        side;
    logic [31:0] limit;
    logic [31:0] stop;
    logic [31:0] qty;
    logic        armed;
  } entry_t;

  typedef struct packed {
    logic [1:0]  rkind;
    logic [1:0]  status;
    logic [15:0] ord_id;
    logic [31:0] price;
    logic [31:0] qty;
    logic        side;
    logic [1:0]  okind;
    logic [6:0]  pending;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/poptm_ram.sv
// ----------------------------------------------------------------------------
// poptm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module poptm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/poptm_front.sv
// ----------------------------------------------------------------------------
// poptm_front
// Accepts requests, decodes the op code and queues commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module poptm_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [2:0]     in_op_i,
  input  wire logic [230:0]   in_data_i,
  output logic                q_valid_o,
  output poptm_pkg::cmd_t     q_data_o,
  input  wire logic           q_pop_i
);
  import poptm_pkg::*;

  cmd_t       fifo_q [2];
  cmd_t       cmd;
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  always_comb begin
    unique case (in_op_i)
      OP_ADD:     cmd.kind = CMD_ADD;
      OP_REMOVE:  cmd.kind = CMD_REMOVE;
      OP_TICK:    cmd.kind = CMD_TICK;
      OP_CLR_PF:  cmd.kind = CMD_CLR_PF;
      OP_CLR_ALL: cmd.kind = CMD_CLR_ALL;
      default:    cmd.kind = CMD_NOP;
    endcase
    cmd.ord_id    = in_data_i[15:0];
    cmd.portfolio = in_data_i[23:16];
    cmd.symbol    = in_data_i[35:24];
    cmd.okind     = in_data_i[37:36];
    cmd.side      = in_data_i[38];
    cmd.limit     = in_data_i[70:39];
    cmd.stop      = in_data_i[102:71];
    cmd.qty       = in_data_i[134:103];
    cmd.bid       = in_data_i[166:135];
    cmd.ask       = in_data_i[198:167];
    cmd.last      = in_data_i[230:199];
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = fifo_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ push;
    rptr_d = rptr_q ^ q_pop_i;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/poptm_back.sv
// ----------------------------------------------------------------------------
// poptm_back
// Executes commands on the order table: append, scan, compaction, results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pending_order_trigger_matcher_top_assert.svh"

module poptm_back #(
  parameter int unsigned NUM_ORDERS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  poptm_pkg::cmd_t        q_data_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output poptm_pkg::result_t     out_data_o
);
  import poptm_pkg::*;

  localparam int unsigned AW = $clog2(NUM_ORDERS);
  localparam int unsigned CW = $clog2(NUM_ORDERS + 1);
  localparam int unsigned EW = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_TURN = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [CW-1:0]   n_q, n_d, idx_q, idx_d, w_q, w_d;
  logic [RCW-1:0]  cnt_q, cnt_d, emit_q, emit_d;
  logic            pass_q, pass_d, found_q, found_d;
  logic [1:0]      status_q, status_d, rk_q, rk_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;

  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  entry_t          wentry, e;
  logic [EW-1:0]   rdata;

  logic [CW-1:0]   idx_nx;
  logic            last_e, out_free, step_ok;
  logic            match_ps, lim_ok, stop_ok, both, arm_new, fill, emit, drop;
  logic [31:0]     px_buy, px_sell, price;

  poptm_ram #(.WIDTH(EW), .DEPTH(NUM_ORDERS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign e        = entry_t'(rdata);
  assign idx_nx   = idx_q + 1'b1;
  assign last_e   = (idx_nx == n_q);
  assign out_free = !out_valid_q || out_ready_i;

  // trigger tests
  always_comb begin
    match_ps = (e.portfolio == cmd_q.portfolio) && (e.symbol == cmd_q.symbol);
    px_buy   = (cmd_q.ask != 32'd0) ? cmd_q.ask : cmd_q.last;
    px_sell  = (cmd_q.bid != 32'd0) ? cmd_q.bid : cmd_q.last;
    lim_ok   = (e.limit != 32'd0) &&
               ((e.side == SIDE_BUY) ? (px_buy <= e.limit) : (px_sell >= e.limit));
    stop_ok  = (e.stop != 32'd0) &&
               ((e.side == SIDE_BUY) ? (cmd_q.last >= e.stop) : (cmd_q.last <= e.stop));
    both     = (e.stop != 32'd0) && (e.limit != 32'd0);
    arm_new  = e.armed || (both && stop_ok);
    unique case (e.okind)
      KIND_LIMIT: begin
        fill  = lim_ok;
        price = e.limit;
      end
      KIND_STOP: begin
        fill  = stop_ok;
        price = e.stop;
      end
      KIND_STOPLIM: begin
        fill  = both && arm_new && lim_ok;
        price = e.limit;
      end
      default: begin
        fill  = 1'b0;
        price = 32'd0;
      end
    endcase
    fill = fill && match_ps;
    emit = (cmd_q.kind == CMD_TICK) && fill && (emit_q < cnt_q);
    unique case (cmd_q.kind)
      CMD_TICK:   drop = emit;
      CMD_REMOVE: drop = !found_q && (e.ord_id == cmd_q.ord_id);
      CMD_CLR_PF: drop = (e.portfolio == cmd_q.portfolio);
      default:    drop = 1'b0;
    endcase
    step_ok = pass_q || !emit || out_free;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    n_d         = n_q;
    idx_d       = idx_q;
    w_d         = w_q;
    cnt_d       = cnt_q;
    emit_d      = emit_q;
    pass_d      = pass_q;
    found_d     = found_q;
    status_d    = status_q;
    rk_d        = rk_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    we          = 1'b0;
    waddr       = '0;
    wentry      = e;
    re          = 1'b0;
    raddr       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          cmd_d    = q_data_i;
          status_d = ST_OK;
          rk_d     = RK_ACK;
          idx_d    = '0;
          w_d      = '0;
          cnt_d    = '0;
          emit_d   = '0;
          found_d  = 1'b0;
          pass_d   = (q_data_i.kind == CMD_TICK);
          state_d  = S_RESP;
          unique case (q_data_i.kind)
            CMD_ADD: begin
              if (q_data_i.portfolio == 8'd0) begin
                status_d = ST_NO_PF;
              end else if (n_q >= CW'(NUM_ORDERS)) begin
                status_d = ST_FULL;
              end else begin
                we               = 1'b1;
                waddr            = n_q[AW-1:0];
                wentry.ord_id    = q_data_i.ord_id;
                wentry.portfolio = q_data_i.portfolio;
                wentry.symbol    = q_data_i.symbol;
                wentry.okind     = q_data_i.okind;
                wentry.side      = q_data_i.side;
                wentry.limit     = q_data_i.limit;
                wentry.stop      = q_data_i.stop;
                wentry.qty       = q_data_i.qty;
                wentry.armed     = 1'b0;
                n_d              = n_q + 1'b1;
              end
            end
            CMD_CLR_ALL: n_d = '0;
            CMD_REMOVE, CMD_TICK, CMD_CLR_PF: begin
              if (q_data_i.kind == CMD_REMOVE) begin
                status_d = ST_NOTFOUND;
              end
              if (q_data_i.kind == CMD_TICK) begin
                rk_d = RK_NOFILL;
              end
              if (n_q != '0) begin
                re      = 1'b1;
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (step_ok) begin
          if (!last_e) begin
            re    = 1'b1;
            raddr = idx_nx[AW-1:0];
            idx_d = idx_nx;
          end
          if (pass_q) begin
            // count pass: arm stop-limits, count fills
            if ((e.okind == KIND_STOPLIM) && match_ps && arm_new && !e.armed) begin
              we           = 1'b1;
              waddr        = idx_q[AW-1:0];
              wentry.armed = 1'b1;
            end
            if (fill && (cnt_q < RCW'(RES_CAP))) begin
              cnt_d = cnt_q + 1'b1;
            end
            if (last_e) begin
              idx_d   = '0;
              pass_d  = 1'b0;
              state_d = S_TURN;
            end
          end else begin
            // compaction pass
            if (emit) begin
              out_valid_d    = 1'b1;
              out_d.rkind    = RK_FILL;
              out_d.status   = ST_OK;
              out_d.ord_id   = e.ord_id;
              out_d.price    = price;
              out_d.qty      = e.qty;
              out_d.side     = e.side;
              out_d.okind    = e.okind;
              out_d.pending  = RCW'(n_q - CW'(cnt_q));
              out_d.last     = ((emit_q + 1'b1) == cnt_q);
              emit_d         = emit_q + 1'b1;
            end
            if (drop && (cmd_q.kind == CMD_REMOVE)) begin
              found_d  = 1'b1;
              status_d = ST_OK;
            end
            if (!drop) begin
              we    = 1'b1;
              waddr = w_q[AW-1:0];
              w_d   = w_q + 1'b1;
            end
            if (last_e) begin
              n_d     = w_d;
              state_d = ((cmd_q.kind == CMD_TICK) && (cnt_q != '0)) ? S_IDLE : S_RESP;
            end
          end
        end
      end

      S_TURN: begin
        re      = 1'b1;
        state_d = S_SCAN;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.rkind    = rk_q;
          out_d.status   = status_q;
          out_d.ord_id   = '0;
          out_d.price    = '0;
          out_d.qty      = '0;
          out_d.side     = 1'b0;
          out_d.okind    = '0;
          out_d.pending  = RCW'(n_q);
          out_d.last     = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    idx_q    <= idx_d;
    w_q      <= w_d;
    status_q <= status_d;
    rk_q     <= rk_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      cnt_q       <= '0;
      emit_q      <= '0;
      pass_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      emit_q      <= emit_d;
      pass_q      <= pass_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `POPTM_ASSERT(a_n_bound, clk_i, rst_ni, n_q <= CW'(NUM_ORDERS), "pending count overflow")
  `POPTM_ASSERT(a_emit_bound, clk_i, rst_ni, emit_q <= cnt_q, "more fills than counted")
  `POPTM_ASSERT(a_cnt_cap, clk_i, rst_ni, cnt_q <= RCW'(RES_CAP), "fill cap exceeded")
  `POPTM_ASSERT_IMPL(a_w_behind, clk_i, rst_ni, state_q == S_SCAN, w_q <= idx_q, "write ahead")

endmodule

`default_nettype wire

>>> hdl/pending_order_trigger_matcher_top.sv
// ----------------------------------------------------------------------------
// pending_order_trigger_matcher_top
// Pending limit/stop/stop-limit order table that fills orders on price ticks.
// ----------------------------------------------------------------------------
// Add, clear all and unused ops do not scan the table. Remove and clear
// portfolio scan the table once. A tick scans it twice (count and arm,
// then emit and compact), and the emit scan can stall on the output.
// The rate is set by the single table RAM, read one entry per cycle while
// the output is not stalled. Up to two requests queue ahead of the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module pending_order_trigger_matcher_top #(
  parameter int unsigned NUM_ORDERS = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // order id, portfolio, symbol_id, order_kind, side, limit, stop,
  // quantity, bid_price, ask_price, last_price, 1 pad bit
  input  wire logic [231:0] s_axis_tdata,
  // op
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status, fill id, fill price, fill_quantity, fill_side, fill_kind,
  // pending_count, 4 pad bits
  output logic [95:0]       m_axis_tdata,
  // result_kind
  output logic [1:0]        m_axis_tuser,
  // last_of_run
  output logic              m_axis_tlast
);
  import poptm_pkg::*;

  logic    q_valid, q_pop;
  cmd_t    q_data;
  result_t res;

  poptm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser),
    .in_data_i  (s_axis_tdata[230:0]),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  poptm_back #(.NUM_ORDERS(NUM_ORDERS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {4'd0, res.pending, res.okind, res.side, res.qty,
                         res.price, res.ord_id, res.status};
  assign m_axis_tuser = res.rkind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
